// ===== rtl/iopmp_erm_pkg.sv =====
// Shared types and constants for the protection entry range match pipeline.
package iopmp_erm_pkg;

	localparam int unsigned ADDR_W = 64;
	localparam int unsigned HALF_W = 32;
	localparam int unsigned LEN_W  = 16;
	localparam int unsigned CFG_W  = 8;

	localparam int unsigned S_TDATA_W = 224;
	localparam int unsigned M_TDATA_W = 136;
	localparam int unsigned APB_AW    = 3;
	localparam int unsigned APB_DW    = 32;

	localparam logic [1:0] MODE_OFF   = 2'd0;
	localparam logic [1:0] MODE_TOR   = 2'd1;
	localparam logic [1:0] MODE_NA4   = 2'd2;
	localparam logic [1:0] MODE_NAPOT = 2'd3;

	localparam logic [1:0] KIND_READ  = 2'd0;
	localparam logic [1:0] KIND_WRITE = 2'd1;
	localparam logic [1:0] KIND_EXEC  = 2'd2;
	localparam logic [1:0] KIND_AMO   = 2'd3;

	localparam logic REG_TOR_ENABLE  = 1'b0;
	localparam logic REG_HIGH_ENABLE = 1'b1;

	typedef struct packed {
		logic tor_enable;
		logic high_addr_enable;
	} cfg_t;

	typedef struct packed {
		logic [CFG_W-1:0]  pmp_cfg;
		logic [HALF_W-1:0] entry_addr_lo;
		logic [HALF_W-1:0] entry_addr_hi;
		logic [HALF_W-1:0] prev_addr_lo;
		logic [HALF_W-1:0] prev_addr_hi;
		logic              is_first_entry;
		logic [ADDR_W-1:0] txn_addr;
		logic [LEN_W-1:0]  txn_len;
		logic [1:0]        txn_kind;
	} req_t;

	typedef struct packed {
		logic [1:0]        mode;
		logic              first;
		logic              active;
		logic              perm;
		logic [ADDR_W-1:0] word;
		logic [ADDR_W-1:0] word_p1;
		logic [ADDR_W-1:0] prev;
		logic [ADDR_W-1:0] taddr;
		logic [ADDR_W-1:0] tend;
	} dec_t;

	typedef struct packed {
		logic              active;
		logic              perm;
		logic [ADDR_W-1:0] base;
		logic [ADDR_W-1:0] size;
		logic [ADDR_W-1:0] taddr;
		logic [ADDR_W-1:0] tend;
	} rgn_t;

	typedef struct packed {
		logic              active;
		logic              perm;
		logic [ADDR_W-1:0] base;
		logic [ADDR_W-1:0] size;
		logic [ADDR_W-1:0] rend;
		logic [ADDR_W-1:0] taddr;
		logic [ADDR_W-1:0] tend;
	} end_t;

	typedef struct packed {
		logic              active;
		logic [ADDR_W-1:0] region_base;
		logic [ADDR_W-1:0] region_size;
		logic              covers_any;
		logic              covers_all;
		logic              permitted;
	} res_t;

endpackage

// ===== rtl/iopmp_erm_cfg.sv =====
// APB register file holding the mode enables.
module iopmp_erm_cfg (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [iopmp_erm_pkg::APB_AW-1:0]    paddr,
	input  logic [iopmp_erm_pkg::APB_DW-1:0]    pwdata,
	output logic [iopmp_erm_pkg::APB_DW-1:0]    prdata,
	output logic                                pready,
	output iopmp_erm_pkg::cfg_t                 cfg
);
	import iopmp_erm_pkg::*;

	logic tor_enable_q;
	logic high_enable_q;
	logic wr_en;
	logic sel;

	// word select only; byte offset bits are ignored
	assign sel    = paddr[2];
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tor_enable_q  <= 1'b1;
			high_enable_q <= 1'b0;
		end else if (wr_en) begin
			unique case (sel)
				REG_TOR_ENABLE:  tor_enable_q  <= pwdata[0];
				REG_HIGH_ENABLE: high_enable_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (sel)
			REG_TOR_ENABLE:  prdata = {{(APB_DW-1){1'b0}}, tor_enable_q};
			REG_HIGH_ENABLE: prdata = {{(APB_DW-1){1'b0}}, high_enable_q};
			default:         prdata = '0;
		endcase
	end

	assign cfg.tor_enable       = tor_enable_q;
	assign cfg.high_addr_enable = high_enable_q;

endmodule

// ===== rtl/iopmp_erm_dec.sv =====
// Stage 1: word assembly, mode and permission decode, increment and end adds.
module iopmp_erm_dec (
	input  logic                  clk,
	input  logic                  arst_n,
	input  iopmp_erm_pkg::cfg_t   cfg,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  iopmp_erm_pkg::req_t   in_req,
	output logic                  out_valid,
	input  logic                  out_ready,
	output iopmp_erm_pkg::dec_t   out_dec
);
	import iopmp_erm_pkg::*;

	logic       v_s1;
	dec_t       dec_s1;
	dec_t       nxt;
	logic       r_bit;
	logic       w_bit;
	logic       x_bit;
	logic [1:0] mode;

	assign mode  = in_req.pmp_cfg[4:3];
	assign r_bit = in_req.pmp_cfg[0];
	assign w_bit = in_req.pmp_cfg[1];
	assign x_bit = in_req.pmp_cfg[2];

	always_comb begin
		nxt.mode    = mode;
		nxt.first   = in_req.is_first_entry;
		nxt.word    = {cfg.high_addr_enable ? in_req.entry_addr_hi : {HALF_W{1'b0}},
			in_req.entry_addr_lo};
		nxt.prev    = {cfg.high_addr_enable ? in_req.prev_addr_hi : {HALF_W{1'b0}},
			in_req.prev_addr_lo};
		nxt.word_p1 = nxt.word + {{(ADDR_W-1){1'b0}}, 1'b1};
		nxt.taddr   = in_req.txn_addr;
		nxt.tend    = in_req.txn_addr + {{(ADDR_W-LEN_W){1'b0}}, in_req.txn_len};
		nxt.active  = !(mode == MODE_OFF || (mode == MODE_TOR && !cfg.tor_enable));
		unique case (in_req.txn_kind)
			KIND_READ:  nxt.perm = r_bit;
			KIND_WRITE: nxt.perm = w_bit;
			KIND_EXEC:  nxt.perm = x_bit;
			default:    nxt.perm = r_bit && w_bit;
		endcase
	end

	assign in_ready = !v_s1 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			dec_s1 <= nxt;
		end
	end

	assign out_valid = v_s1;
	assign out_dec   = dec_s1;

endmodule

// ===== rtl/iopmp_erm_rgn.sv =====
// Stage 2: region base and size per address mode.
module iopmp_erm_rgn (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  iopmp_erm_pkg::dec_t   in_dec,
	output logic                  out_valid,
	input  logic                  out_ready,
	output iopmp_erm_pkg::rgn_t   out_rgn
);
	import iopmp_erm_pkg::*;

	logic              v_s2;
	rgn_t              rgn_s2;
	rgn_t              nxt;
	logic [ADDR_W-1:0] top;
	logic [ADDR_W-1:0] tor_base;
	logic [ADDR_W-1:0] napot_w;
	logic [ADDR_W-1:0] low_zero;

	// w & (w+1) clears trailing ones; ~w & (w+1) is the lowest zero bit
	assign napot_w  = in_dec.word & in_dec.word_p1;
	assign low_zero = ~in_dec.word & in_dec.word_p1;
	assign top      = {in_dec.word[ADDR_W-3:0], 2'b00};
	assign tor_base = in_dec.first ? {ADDR_W{1'b0}} : {in_dec.prev[ADDR_W-3:0], 2'b00};

	always_comb begin
		nxt.active = in_dec.active;
		nxt.perm   = in_dec.perm;
		nxt.taddr  = in_dec.taddr;
		nxt.tend   = in_dec.tend;
		unique case (in_dec.mode)
			MODE_NA4: begin
				nxt.base = top;
				nxt.size = 64'd4;
			end
			MODE_NAPOT: begin
				nxt.base = {napot_w[ADDR_W-3:0], 2'b00};
				nxt.size = {low_zero[ADDR_W-4:0], 3'b000};
			end
			MODE_TOR: begin
				nxt.base = tor_base;
				nxt.size = (top > tor_base) ? (top - tor_base) : {ADDR_W{1'b0}};
			end
			default: begin
				nxt.base = '0;
				nxt.size = '0;
			end
		endcase
	end

	assign in_ready = !v_s2 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (in_ready) begin
			v_s2 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			rgn_s2 <= nxt;
		end
	end

	assign out_valid = v_s2;
	assign out_rgn   = rgn_s2;

endmodule

// ===== rtl/iopmp_erm_cmp.sv =====
// Stages 3 and 4: region end add, then overlap and containment compares.
module iopmp_erm_cmp (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  iopmp_erm_pkg::rgn_t   in_rgn,
	output logic                  out_valid,
	input  logic                  out_ready,
	output iopmp_erm_pkg::res_t   out_res
);
	import iopmp_erm_pkg::*;

	logic v_s3;
	logic v_s4;
	logic rdy_s3;
	logic rdy_s4;
	end_t end_s3;
	end_t nxt3;
	res_t res_s4;
	res_t nxt4;

	always_comb begin
		nxt3.active = in_rgn.active;
		nxt3.perm   = in_rgn.perm;
		nxt3.base   = in_rgn.base;
		nxt3.size   = in_rgn.size;
		nxt3.rend   = in_rgn.base + in_rgn.size;
		nxt3.taddr  = in_rgn.taddr;
		nxt3.tend   = in_rgn.tend;
	end

	always_comb begin
		nxt4.active      = end_s3.active;
		nxt4.permitted   = end_s3.perm;
		nxt4.region_base = end_s3.base;
		nxt4.region_size = end_s3.size;
		nxt4.covers_any  = (end_s3.taddr < end_s3.rend) && (end_s3.base < end_s3.tend);
		nxt4.covers_all  = (end_s3.taddr >= end_s3.base) && (end_s3.tend <= end_s3.rend);
	end

	assign rdy_s4   = !v_s4 || out_ready;
	assign rdy_s3   = !v_s3 || rdy_s4;
	assign in_ready = rdy_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy_s3) begin
				v_s3 <= in_valid;
			end
			if (rdy_s4) begin
				v_s4 <= v_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s3 && in_valid) begin
			end_s3 <= nxt3;
		end
		if (rdy_s4 && v_s3) begin
			res_s4 <= nxt4;
		end
	end

	assign out_valid = v_s4;
	assign out_res   = res_s4;

endmodule

// ===== rtl/iopmp_entry_range_match_top.sv =====
// Top level: one transaction checked against one protection entry per request.
// One request per cycle sustained while the receiver holds m_tready high.
// Four register stages (decode, region, end add, compare), each stalls on its own valid bit.
// Reset clears all stage valid bits; tor_enable resets to 1, high_addr_enable to 0.
module iopmp_entry_range_match_top (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	// pmp_cfg, entry_addr_lo, entry_addr_hi, prev_addr_lo, prev_addr_hi,
	// is_first_entry, txn_addr, txn_len, zero pad
	input  logic [iopmp_erm_pkg::S_TDATA_W-1:0]   s_tdata,
	// txn_kind
	input  logic [1:0]                            s_tuser,
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	// active, region_base, region_size, covers_any, covers_all, permitted, zero pad
	output logic [iopmp_erm_pkg::M_TDATA_W-1:0]   m_tdata,
	input  logic                                  psel,
	input  logic                                  penable,
	input  logic                                  pwrite,
	input  logic [iopmp_erm_pkg::APB_AW-1:0]      paddr,
	input  logic [iopmp_erm_pkg::APB_DW-1:0]      pwdata,
	output logic [iopmp_erm_pkg::APB_DW-1:0]      prdata,
	output logic                                  pready
);
	import iopmp_erm_pkg::*;

	cfg_t cfg;
	req_t req;
	dec_t dec;
	rgn_t rgn;
	res_t res;
	logic dec_valid;
	logic dec_ready;
	logic rgn_valid;
	logic rgn_ready;

	assign req.pmp_cfg        = s_tdata[7:0];
	assign req.entry_addr_lo  = s_tdata[39:8];
	assign req.entry_addr_hi  = s_tdata[71:40];
	assign req.prev_addr_lo   = s_tdata[103:72];
	assign req.prev_addr_hi   = s_tdata[135:104];
	assign req.is_first_entry = s_tdata[136];
	assign req.txn_addr       = s_tdata[200:137];
	assign req.txn_len        = s_tdata[216:201];
	assign req.txn_kind       = s_tuser;

	iopmp_erm_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	iopmp_erm_dec u_dec (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_req    (req),
		.out_valid (dec_valid),
		.out_ready (dec_ready),
		.out_dec   (dec)
	);

	iopmp_erm_rgn u_rgn (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (dec_valid),
		.in_ready  (dec_ready),
		.in_dec    (dec),
		.out_valid (rgn_valid),
		.out_ready (rgn_ready),
		.out_rgn   (rgn)
	);

	iopmp_erm_cmp u_cmp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (rgn_valid),
		.in_ready  (rgn_ready),
		.in_rgn    (rgn),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (res)
	);

	assign m_tdata = {4'b0000, res.permitted, res.covers_all, res.covers_any,
		res.region_size, res.region_base, res.active};

endmodule

// ===== tb/sv/tb_iopmp_entry_range_match_top.sv =====
// Testbench: streams entry/transaction requests into the range matcher and checks every result.
module tb_iopmp_entry_range_match_top;
	import iopmp_erm_pkg::*;

	localparam int LATENCY     = 4;
	localparam int IDLE_LIMIT  = 3000;
	localparam int HOLD_CYCLES = 150;
	localparam int PHASE_ITEMS = 375;

	localparam logic [APB_AW-1:0] ADDR_TOR_ENABLE  = APB_AW'(4 * REG_TOR_ENABLE);
	localparam logic [APB_AW-1:0] ADDR_HIGH_ENABLE = APB_AW'(4 * REG_HIGH_ENABLE);

	localparam int PERM_R = 0;
	localparam int PERM_W = 1;
	localparam int PERM_X = 2;

	localparam logic [2:0] RWX_NONE = 3'b000;
	localparam logic [2:0] RWX_R    = 3'b001;
	localparam logic [2:0] RWX_RW   = 3'b011;
	localparam logic [2:0] RWX_X    = 3'b100;
	localparam logic [2:0] RWX_ALL  = 3'b111;

	class match_scoreboard;
		bit   tor_en;
		bit   high_en;
		res_t pending[$];
		int   errors;
		int   checked;

		function new();
			tor_en  = 1'b1;
			high_en = 1'b0;
		endfunction

		function res_t predict(req_t r);
			logic [63:0] word, prev, base, size, top, rend, tend, mask;
			logic [1:0]  mode;
			int          k;
			res_t        e;
			word = {high_en ? r.entry_addr_hi : 32'h0, r.entry_addr_lo};
			prev = {high_en ? r.prev_addr_hi : 32'h0, r.prev_addr_lo};
			mode = r.pmp_cfg[4:3];
			base = '0;
			size = '0;
			case (mode)
				MODE_NA4: begin
					base = word << 2;
					size = 64'd4;
				end
				MODE_NAPOT: begin
					k = 0;
					while (k < 64 && word[k] == 1'b1)
						k++;
					if (k < 64) begin
						mask = (64'd1 << k) - 64'd1;
						base = (word & ~mask) << 2;
						size = 64'd8 << k;
					end
				end
				MODE_TOR: begin
					top  = word << 2;
					base = r.is_first_entry ? 64'd0 : (prev << 2);
					size = (top > base) ? (top - base) : 64'd0;
				end
				default: ;
			endcase
			rend = base + size;
			tend = r.txn_addr + {48'h0, r.txn_len};
			e.active      = !(mode == MODE_OFF || (mode == MODE_TOR && !tor_en));
			e.region_base = base;
			e.region_size = size;
			e.covers_any  = (r.txn_addr < rend) && (base < tend);
			e.covers_all  = (r.txn_addr >= base) && (tend <= rend);
			case (r.txn_kind)
				KIND_READ:  e.permitted = r.pmp_cfg[PERM_R];
				KIND_WRITE: e.permitted = r.pmp_cfg[PERM_W];
				KIND_EXEC:  e.permitted = r.pmp_cfg[PERM_X];
				default:    e.permitted = r.pmp_cfg[PERM_R] & r.pmp_cfg[PERM_W];
			endcase
			return e;
		endfunction

		function void note_request(req_t r);
			pending.push_back(predict(r));
		endfunction

		task report(string what, logic [63:0] got, logic [63:0] exp);
			$display("mismatch %s: got %h expected %h", what, got, exp);
			errors++;
		endtask

		task check_result(res_t got);
			res_t e;
			if (pending.size() == 0) begin
				report("result with no request pending", got.region_base, 64'h0);
			end else begin
				e = pending.pop_front();
				checked++;
				if (got.active !== e.active)
					report("active", 64'(got.active), 64'(e.active));
				if (got.region_base !== e.region_base)
					report("region_base", got.region_base, e.region_base);
				if (got.region_size !== e.region_size)
					report("region_size", got.region_size, e.region_size);
				if (got.covers_any !== e.covers_any)
					report("covers_any", 64'(got.covers_any), 64'(e.covers_any));
				if (got.covers_all !== e.covers_all)
					report("covers_all", 64'(got.covers_all), 64'(e.covers_all));
				if (got.permitted !== e.permitted)
					report("permitted", 64'(got.permitted), 64'(e.permitted));
			end
		endtask
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	// pmp_cfg, entry_addr_lo, entry_addr_hi, prev_addr_lo, prev_addr_hi,
	// is_first_entry, txn_addr, txn_len, zero pad
	logic [S_TDATA_W-1:0] s_tdata;
	// txn_kind
	logic [1:0]           s_tuser;
	logic                 m_tvalid;
	logic                 m_tready;
	// active, region_base, region_size, covers_any, covers_all, permitted, zero pad
	logic [M_TDATA_W-1:0] m_tdata;
	logic                 psel;
	logic                 penable;
	logic                 pwrite;
	logic [APB_AW-1:0]    paddr;
	logic [APB_DW-1:0]    pwdata;
	logic [APB_DW-1:0]    prdata;
	logic                 pready;

	match_scoreboard sb;
	int              sent;
	int              settings_run;
	int              idle_cycles;
	bit              hold_req;
	bit              hold_done;
	int              hold_cnt;

	iopmp_entry_range_match_top u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task send_request(req_t r);
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata  <= {7'b0, r.txn_len, r.txn_addr, r.is_first_entry, r.prev_addr_hi,
			r.prev_addr_lo, r.entry_addr_hi, r.entry_addr_lo, r.pmp_cfg};
		s_tuser  <= r.txn_kind;
		forever begin
			@(posedge clk);
			if (s_tready)
				break;
		end
		sb.note_request(r);
		sent++;
	endtask

	task send_fields(logic [1:0] mode, logic [2:0] rwx, logic [31:0] elo, logic [31:0] ehi,
			logic [31:0] plo, logic [31:0] phi, logic first, logic [63:0] addr,
			logic [15:0] len, logic [1:0] kind);
		req_t r;
		r.pmp_cfg        = {3'b000, mode, rwx};
		r.entry_addr_lo  = elo;
		r.entry_addr_hi  = ehi;
		r.prev_addr_lo   = plo;
		r.prev_addr_hi   = phi;
		r.is_first_entry = first;
		r.txn_addr       = addr;
		r.txn_len        = len;
		r.txn_kind       = kind;
		send_request(r);
	endtask

	task apb_access(logic wr, logic [APB_AW-1:0] addr, logic [APB_DW-1:0] wdata,
			output logic [APB_DW-1:0] rdata);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= addr;
		pwdata  <= wdata;
		@(negedge clk);
		penable <= 1'b1;
		forever begin
			@(posedge clk);
			if (pready)
				break;
		end
		rdata = prdata;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task set_config(bit tor, bit high);
		logic [APB_DW-1:0] rd;
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 2) @(posedge clk);
		apb_access(1'b1, ADDR_TOR_ENABLE, APB_DW'(tor), rd);
		apb_access(1'b1, ADDR_HIGH_ENABLE, APB_DW'(high), rd);
		apb_access(1'b0, ADDR_TOR_ENABLE, '0, rd);
		if (rd !== APB_DW'(tor))
			sb.report("tor_enable readback", 64'(rd), 64'(tor));
		apb_access(1'b0, ADDR_HIGH_ENABLE, '0, rd);
		if (rd !== APB_DW'(high))
			sb.report("high_addr_enable readback", 64'(rd), 64'(high));
		sb.tor_en  = tor;
		sb.high_en = high;
		settings_run++;
	endtask

	function req_t random_request();
		req_t        r;
		logic [63:0] w, p;
		res_t        e;
		int          k;
		logic [63:0] off;
		r.pmp_cfg = 8'($urandom);
		case ($urandom_range(0, 3))
			0: w = {$urandom, $urandom};
			1: begin
				k = $urandom_range(0, 40);
				w = ({$urandom, $urandom} << (k + 1)) | ((64'd1 << k) - 64'd1);
				if ($urandom_range(0, 15) == 0)
					w = '1;
			end
			2: w = 64'($urandom_range(0, 4096));
			default: w = {32'($urandom_range(0, 3)), $urandom};
		endcase
		if ($urandom_range(0, 1))
			p = w - 64'($urandom_range(0, 2048));
		else
			p = {$urandom, $urandom};
		r.entry_addr_lo  = w[31:0];
		r.entry_addr_hi  = w[63:32];
		r.prev_addr_lo   = p[31:0];
		r.prev_addr_hi   = p[63:32];
		r.is_first_entry = 1'($urandom_range(0, 1));
		r.txn_kind       = 2'($urandom);
		r.txn_len        = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 64));
		r.txn_addr       = {$urandom, $urandom};
		e   = sb.predict(r);
		off = 64'($urandom_range(0, 64)) - 64'd32;
		case ($urandom_range(0, 3))
			0: ;
			1: r.txn_addr = e.region_base + off;
			2: r.txn_addr = e.region_base + e.region_size - {48'h0, r.txn_len} + off;
			default: r.txn_addr = e.region_base + 64'($urandom_range(0, 255));
		endcase
		return r;
	endfunction

	task run_random(int count);
		int burst;
		int gap;
		burst = 0;
		repeat (count) begin
			if (burst == 0) begin
				burst = $urandom_range(1, 30);
				gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
				repeat (gap) begin
					@(negedge clk);
					s_tvalid <= 1'b0;
				end
			end
			burst--;
			send_request(random_request());
		end
		@(negedge clk);
		s_tvalid <= 1'b0;
	endtask

	// receiver backpressure: shifting patterns plus one long hold-off
	initial begin
		int mode;
		int span;
		int phase;
		wait (arst_n);
		phase = 0;
		forever begin
			mode = $urandom_range(0, 3);
			span = $urandom_range(20, 300);
			repeat (span) begin
				@(negedge clk);
				phase++;
				if (hold_req && !hold_done) begin
					m_tready <= 1'b0;
					hold_cnt++;
					if (hold_cnt == HOLD_CYCLES)
						hold_done = 1'b1;
				end else begin
					case (mode)
						0: m_tready <= 1'b1;
						1: m_tready <= 1'($urandom_range(0, 1));
						2: m_tready <= (phase % 4 == 0);
						default: m_tready <= ($urandom_range(0, 9) != 0);
					endcase
				end
			end
		end
	end

	always @(posedge clk) begin
		res_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got.active      = m_tdata[0];
			got.region_base = m_tdata[64:1];
			got.region_size = m_tdata[128:65];
			got.covers_any  = m_tdata[129];
			got.covers_all  = m_tdata[130];
			got.permitted   = m_tdata[131];
			sb.check_result(got);
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("watchdog: no traffic for %0d cycles, %0d results pending",
				idle_cycles, sb.pending.size());
			$display("FAIL iopmp_entry_range_match_top");
			$finish;
		end
	end

	initial begin
		sb           = new();
		sent         = 0;
		settings_run = 1;
		idle_cycles  = 0;
		hold_req     = 1'b0;
		hold_done    = 1'b0;
		hold_cnt     = 0;
		arst_n       = 1'b0;
		s_tvalid     = 1'b0;
		s_tdata      = '0;
		s_tuser      = '0;
		m_tready     = 1'b0;
		psel         = 1'b0;
		penable      = 1'b0;
		pwrite       = 1'b0;
		paddr        = '0;
		pwdata       = '0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;

		// reset settings: tor enabled, high words ignored
		send_fields(MODE_OFF, RWX_ALL, 32'h100, 32'h0, 32'h0, 32'h0, 1'b0, 64'h0, 16'd0,
			KIND_READ);
		send_fields(MODE_NA4, RWX_ALL, 32'h100, 32'hFFFF_FFFF, 32'h0, 32'h0, 1'b0, 64'h400,
			16'd4, KIND_READ);
		send_fields(MODE_NA4, RWX_RW, 32'h100, 32'h0, 32'h0, 32'h0, 1'b0, 64'h3FE, 16'd4,
			KIND_WRITE);
		send_fields(MODE_NAPOT, RWX_R, 32'h1FF, 32'h0, 32'h0, 32'h0, 1'b0, 64'h800, 16'd16,
			KIND_WRITE);
		send_fields(MODE_NAPOT, RWX_ALL, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 32'h0, 1'b0,
			64'h10, 16'd8, KIND_EXEC);
		send_fields(MODE_TOR, RWX_X, 32'h1000, 32'h0, 32'h800, 32'h0, 1'b1, 64'h0, 16'd16,
			KIND_EXEC);
		send_fields(MODE_TOR, RWX_RW, 32'h1000, 32'h0, 32'h800, 32'h0, 1'b0, 64'h2000,
			16'd32, KIND_AMO);
		send_fields(MODE_TOR, RWX_ALL, 32'h1000, 32'h0, 32'h2000, 32'h0, 1'b0, 64'h4000,
			16'd4, KIND_READ);
		send_fields(MODE_TOR, RWX_ALL, 32'h1000, 32'h0, 32'h1000, 32'h0, 1'b0, 64'h4000,
			16'd0, KIND_WRITE);
		send_fields(MODE_NA4, RWX_R, 32'h40, 32'h0, 32'h0, 32'h0, 1'b0, 64'h100, 16'd4,
			KIND_AMO);
		send_fields(MODE_NAPOT, RWX_NONE, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0, 64'h0,
			16'hFFFF, KIND_READ);
		send_fields(MODE_NAPOT, RWX_ALL, 32'h7, 32'h0, 32'h0, 32'h0, 1'b0, 64'h0, 16'd0,
			KIND_WRITE);
		send_req_full_cfg: begin
			req_t r;
			r = '0;
			r.pmp_cfg = 8'hFF;
			r.entry_addr_lo = 32'hFFFF_FFFF;
			r.txn_addr = 64'hFFFF_FFFF_FFFF_FFFF;
			r.txn_len = 16'hFFFF;
			r.txn_kind = KIND_AMO;
			send_request(r);
		end
		@(negedge clk);
		s_tvalid <= 1'b0;

		// top-of-range disabled, high words used
		set_config(1'b0, 1'b1);
		send_fields(MODE_TOR, RWX_ALL, 32'h1000, 32'h0, 32'h800, 32'h0, 1'b0, 64'h2000,
			16'd16, KIND_READ);
		send_fields(MODE_NAPOT, RWX_ALL, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 32'h0, 1'b0,
			64'h0, 16'd64, KIND_READ);
		send_fields(MODE_NAPOT, RWX_RW, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h0, 32'h0, 1'b0,
			64'h100, 16'd4, KIND_AMO);
		send_fields(MODE_NA4, RWX_ALL, 32'hFFFF_FFFF, 32'h3FFF_FFFF, 32'h0, 32'h0, 1'b0,
			64'hFFFF_FFFF_FFFF_FFFC, 16'd4, KIND_WRITE);
		send_fields(MODE_NAPOT, RWX_X, 32'hFFFF_FFFE, 32'h3FFF_FFFF, 32'h0, 32'h0, 1'b0,
			64'hFFFF_FFFF_FFFF_FFF0, 16'h100, KIND_EXEC);
		send_fields(MODE_TOR, RWX_R, 32'h0, 32'h8000_0000, 32'h0, 32'h4000_0000, 1'b0,
			64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF, KIND_EXEC);
		send_fields(MODE_TOR, RWX_ALL, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 32'h0, 1'b1,
			64'h0, 16'hFFFF, KIND_WRITE);
		@(negedge clk);
		s_tvalid <= 1'b0;

		set_config(1'b1, 1'b1);
		hold_req = 1'b1;
		run_random(PHASE_ITEMS);
		set_config(1'b0, 1'b0);
		run_random(PHASE_ITEMS);
		set_config(1'b1, 1'b0);
		run_random(PHASE_ITEMS);
		set_config(1'b0, 1'b1);
		run_random(PHASE_ITEMS);

		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (LATENCY * 4) @(posedge clk);
		if (sb.pending.size() != 0)
			sb.report("requests left without a result", 64'(sb.pending.size()), 64'd0);
		$display("%0d requests sent under %0d register settings, %0d results checked",
			sent, settings_run, sb.checked);
		$display("modes OFF/TOR/NA4/NAPOT, all kinds, wrapped ends, receiver hold-off of %0d",
			HOLD_CYCLES);
		if (sb.errors == 0) begin
			$display("PASS iopmp_entry_range_match_top");
		end else begin
			$display("%0d mismatches", sb.errors);
			$display("FAIL iopmp_entry_range_match_top");
		end
		$finish;
	end

endmodule
